[sv/vsar_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the video scroll address register block.
// No dependencies; every other file of the block imports this package.
package vsar_pkg;

	// Item opcodes
	localparam logic [3:0] OP_READ       = 4'd0;
	localparam logic [3:0] OP_WRITE      = 4'd1;
	localparam logic [3:0] OP_COARSE_X   = 4'd2;
	localparam logic [3:0] OP_FINE_Y     = 4'd3;
	localparam logic [3:0] OP_COPY_HORIZ = 4'd4;
	localparam logic [3:0] OP_COPY_VERT  = 4'd5;
	localparam logic [3:0] OP_VBLANK     = 4'd6;
	localparam logic [3:0] OP_FRAME_CLR  = 4'd7;
	localparam logic [3:0] OP_SPR0_HIT   = 4'd8;

	// CPU register numbers
	localparam logic [2:0] REG_CONTROL  = 3'd0;
	localparam logic [2:0] REG_MASK     = 3'd1;
	localparam logic [2:0] REG_STATUS   = 3'd2;
	localparam logic [2:0] REG_OAM_ADDR = 3'd3;
	localparam logic [2:0] REG_OAM_DATA = 3'd4;
	localparam logic [2:0] REG_SCROLL   = 3'd5;
	localparam logic [2:0] REG_ADDR     = 3'd6;
	localparam logic [2:0] REG_DATA     = 3'd7;

	// Start of palette space; data reads at or above skip the buffer
	localparam logic [15:0] PALETTE_BASE = 16'h3f00;

	typedef struct packed {
		logic [3:0] opcode;
		logic [2:0] reg_index;
		logic [7:0] write_data;
		logic [7:0] vram_read_data;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        vram_write_enable;
		logic [15:0] vram_write_address;
		logic [7:0]  vram_write_data;
		logic        oam_write_enable;
		logic [7:0]  oam_write_address;
		logic [7:0]  oam_write_data;
		logic        nmi_request;
		logic [15:0] current_address;
		logic [2:0]  fine_x_scroll;
		logic [7:0]  control_byte;
		logic [7:0]  mask_byte;
	} result_t;

	// Horizontal tile step: wrap coarse X and switch horizontal nametable
	function automatic logic [15:0] coarse_x_inc(input logic [15:0] v);
		logic [15:0] r;
		if (v[4:0] == 5'h1f) begin
			r = {v[15:11], ~v[10], v[9:5], 5'h00};
		end else begin
			r = v + 16'd1;
		end
		return r;
	endfunction

	// Vertical pixel step: fine Y, then coarse Y with the row 29 wrap
	function automatic logic [15:0] fine_y_inc(input logic [15:0] v);
		logic [15:0] r;
		r = v;
		if (v[14:12] != 3'h7) begin
			r[14:12] = v[14:12] + 3'd1;
		end else begin
			r[14:12] = 3'h0;
			if (v[9:5] == 5'd29) begin
				r[9:5] = 5'd0;
				r[11]  = ~v[11];
			end else if (v[9:5] == 5'd31) begin
				r[9:5] = 5'd0;
			end else begin
				r[9:5] = v[9:5] + 5'd1;
			end
		end
		return r;
	endfunction

endpackage

[sv/vsar_core.sv]
`timescale 1ns / 1ps
// Register state and combinational update logic of the scroll address block.
// Depends on vsar_pkg for the item and result types and the codes.
module vsar_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  vsar_pkg::item_t  item,
	output vsar_pkg::result_t result
);
	import vsar_pkg::*;

	logic [15:0] vaddr_q, vaddr_d;
	logic [14:0] taddr_q, taddr_d;
	logic [2:0]  fine_x_q, fine_x_d;
	logic        toggle_q, toggle_d;
	logic [7:0]  rbuf_q, rbuf_d;
	logic [7:0]  oam_ptr_q, oam_ptr_d;
	logic [7:0]  ctrl_q, ctrl_d;
	logic [7:0]  mask_q, mask_d;
	logic        vblank_q, vblank_d;
	logic        spr0_q, spr0_d;
	logic        rendering;
	logic [15:0] port_step;

	assign rendering = |mask_q[4:3];
	assign port_step = ctrl_q[2] ? 16'd32 : 16'd1;

	always_comb begin
		vaddr_d   = vaddr_q;
		taddr_d   = taddr_q;
		fine_x_d  = fine_x_q;
		toggle_d  = toggle_q;
		rbuf_d    = rbuf_q;
		oam_ptr_d = oam_ptr_q;
		ctrl_d    = ctrl_q;
		mask_d    = mask_q;
		vblank_d  = vblank_q;
		spr0_d    = spr0_q;
		result    = '0;

		unique case (item.opcode)
			OP_READ: begin
				if (item.reg_index == REG_STATUS) begin
					result.read_data = {vblank_q, spr0_q, 6'd0};
					vblank_d = 1'b0;
					toggle_d = 1'b0;
				end else if (item.reg_index == REG_DATA) begin
					if (vaddr_q < PALETTE_BASE) begin
						result.read_data = rbuf_q;
						rbuf_d = item.vram_read_data;
					end else begin
						result.read_data = item.vram_read_data;
					end
					vaddr_d = vaddr_q + port_step;
				end
			end
			OP_WRITE: begin
				unique case (item.reg_index)
					REG_CONTROL: begin
						ctrl_d  = item.write_data;
						taddr_d = {taddr_q[14:12], item.write_data[1:0], taddr_q[9:0]};
					end
					REG_MASK: mask_d = item.write_data;
					REG_OAM_ADDR: oam_ptr_d = item.write_data;
					REG_OAM_DATA: begin
						result.oam_write_enable  = 1'b1;
						result.oam_write_address = oam_ptr_q;
						result.oam_write_data    = item.write_data;
						oam_ptr_d = oam_ptr_q + 8'd1;
					end
					REG_SCROLL: begin
						if (!toggle_q) begin
							fine_x_d = item.write_data[2:0];
							taddr_d  = {taddr_q[14:5], item.write_data[7:3]};
						end else begin
							taddr_d = {item.write_data[2:0], taddr_q[11:10],
								item.write_data[7:3], taddr_q[4:0]};
						end
						toggle_d = ~toggle_q;
					end
					REG_ADDR: begin
						if (!toggle_q) begin
							taddr_d = {1'b0, item.write_data[5:0], taddr_q[7:0]};
						end else begin
							taddr_d = {taddr_q[14:8], item.write_data};
							vaddr_d = {1'b0, taddr_q[14:8], item.write_data};
						end
						toggle_d = ~toggle_q;
					end
					REG_DATA: begin
						result.vram_write_enable  = 1'b1;
						result.vram_write_address = vaddr_q;
						result.vram_write_data    = item.write_data;
						vaddr_d = vaddr_q + port_step;
					end
					default: ;
				endcase
			end
			OP_COARSE_X: if (rendering) vaddr_d = coarse_x_inc(vaddr_q);
			OP_FINE_Y:   if (rendering) vaddr_d = fine_y_inc(vaddr_q);
			OP_COPY_HORIZ: begin
				if (rendering) begin
					vaddr_d = {vaddr_q[15:11], taddr_q[10], vaddr_q[9:5], taddr_q[4:0]};
				end
			end
			OP_COPY_VERT: begin
				if (rendering) begin
					vaddr_d = {vaddr_q[15], taddr_q[14:11], vaddr_q[10],
						taddr_q[9:5], vaddr_q[4:0]};
				end
			end
			OP_VBLANK: begin
				vblank_d = 1'b1;
				result.nmi_request = ctrl_q[7];
			end
			OP_FRAME_CLR: begin
				vblank_d = 1'b0;
				spr0_d   = 1'b0;
			end
			OP_SPR0_HIT: spr0_d = 1'b1;
			default: ;
		endcase

		result.current_address = vaddr_d;
		result.fine_x_scroll   = fine_x_d;
		result.control_byte    = ctrl_d;
		result.mask_byte       = mask_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vaddr_q   <= '0;
			taddr_q   <= '0;
			fine_x_q  <= '0;
			toggle_q  <= 1'b0;
			rbuf_q    <= '0;
			oam_ptr_q <= '0;
			ctrl_q    <= '0;
			mask_q    <= '0;
			vblank_q  <= 1'b0;
			spr0_q    <= 1'b0;
		end else if (fire) begin
			vaddr_q   <= vaddr_d;
			taddr_q   <= taddr_d;
			fine_x_q  <= fine_x_d;
			toggle_q  <= toggle_d;
			rbuf_q    <= rbuf_d;
			oam_ptr_q <= oam_ptr_d;
			ctrl_q    <= ctrl_d;
			mask_q    <= mask_d;
			vblank_q  <= vblank_d;
			spr0_q    <= spr0_d;
		end
	end

endmodule

[sv/video_scroll_address_registers.sv]
`timescale 1ns / 1ps
// Channel   Dir  Handshake                  Payload
// item      in   item_valid / item_stall     vsar_pkg::item_t   (opcode, reg, data, vram byte)
// result    out  result_valid / result_stall vsar_pkg::result_t (one per item)
//
// Throughput is one transaction per cycle while the result is not stalled; an accepted
// item passes through the input register, then the result register.
// The update logic in vsar_core sits between those two registers and sets
// the clock period. arst_n clears all state and both valid bits at once;
// no clearing pass is needed. A stalled result holds the pipeline: item_stall
// rises only when the input register is full and the result cannot drain.
//
// Top level of the video scroll address register block.
// Depends on vsar_pkg and vsar_core.
module video_scroll_address_registers (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  vsar_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output vsar_pkg::result_t result
);
	import vsar_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t core_result;
	logic    advance;
	logic    fire;

	// Move forward whenever the result register is empty or being drained
	assign advance    = !(valid_s2 && result_stall);
	assign fire       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	// Input register: load a new transaction whenever not stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// State update and result formation; state commits only on fire
	vsar_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (core_result)
	);

	// Result register: hold while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= core_result;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

[sv/vsar_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the scroll address register block, with the bind
// that attaches them to the top level. Depends on vsar_pkg.
module vsar_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input vsar_pkg::result_t result
);
	import vsar_pkg::*;

	// Hold a stalled result unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	// NMI only with control bit 7, and never with a memory write
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.nmi_request |->
			result.control_byte[7] && !result.vram_write_enable && !result.oam_write_enable)
		else $error("nmi_request inconsistent");

	// Zero the video write fields when no write is issued
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.vram_write_enable |->
			result.vram_write_address == 16'd0 && result.vram_write_data == 8'd0)
		else $error("vram write fields not zero");

	// Zero the sprite write fields when no write is issued
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.oam_write_enable |->
			result.oam_write_address == 8'd0 && result.oam_write_data == 8'd0)
		else $error("oam write fields not zero");

	// A write transaction returns no read byte and writes only one of the two memories
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.vram_write_enable || result.oam_write_enable) |->
			result.read_data == 8'd0 && !(result.vram_write_enable && result.oam_write_enable))
		else $error("write with read data");

endmodule

bind video_scroll_address_registers vsar_checker u_vsar_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
